/* hw/rtl/rzc_pkg.sv */
// Package for the redzone access checker: sizes, command and status codes.
// No dependencies.
`default_nettype none
package rzc_pkg;
	localparam int LIVE_ENTRIES = 64;
	localparam int FREED_ENTRIES = 32;
	localparam int LW = $clog2(LIVE_ENTRIES);
	localparam int FW = $clog2(FREED_ENTRIES);

	localparam logic [2:0] CMD_ALLOC = 3'd0;
	localparam logic [2:0] CMD_FREE = 3'd1;
	localparam logic [2:0] CMD_READ = 3'd2;
	localparam logic [2:0] CMD_WRITE = 3'd3;
	localparam logic [2:0] CMD_TICK = 3'd4;

	localparam logic [3:0] ST_OK = 4'd0;
	localparam logic [3:0] ST_NULL = 4'd1;
	localparam logic [3:0] ST_WFREED = 4'd2;
	localparam logic [3:0] ST_RFREED = 4'd3;
	localparam logic [3:0] ST_UNDERW = 4'd4;
	localparam logic [3:0] ST_OVERW = 4'd5;
	localparam logic [3:0] ST_UNDERR = 4'd6;
	localparam logic [3:0] ST_OVERR = 4'd7;
	localparam logic [3:0] ST_REFREE = 4'd8;
	localparam logic [3:0] ST_BADFREE = 4'd9;
	localparam logic [3:0] ST_FULL = 4'd10;

	localparam logic CFG_RZ = 1'b0;
	localparam logic CFG_AGE = 1'b1;
endpackage
`default_nettype wire

/* hw/rtl/rzc_ram.sv */
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
`default_nettype none
module rzc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

/* hw/rtl/redzone_access_checker.sv */
// Redzone access checker top level: command sequencer, region tables, one compare unit.
// Depends on rzc_pkg and rzc_ram.
//
// Usage: a request (command, address, length) is taken on in_valid/in_ready;
// one result (status, uninit_read) leaves on out_valid/out_ready. Config
// writes (cfg_index 0 redzone_size, 1 free_age) are taken whenever
// cfg_valid is high; they must only be issued while idle.
// Alloc and tick go straight to the result state. Read/write walk the live
// table entry by entry, then the freed table. Free walks the live table,
// then compacts both tables entry by entry (removal and aging each move
// entries one at a time). Each table has a single RAM read port.
// One request is worked on at a time; in_ready is low until the result has
// been taken. A stalled receiver holds the result and the block.
// Reset: both tables empty, tick counter zero, redzone_size 4, free_age 60.
// No clearing pass: valid prefix lengths are kept as counts.
`default_nettype none
module redzone_access_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [2:0] command,
	input wire logic [31:0] address,
	input wire logic [31:0] length,
	output logic out_valid,
	input wire logic out_ready,
	output logic [3:0] status,
	output logic uninit_read,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [0:0] cfg_index,
	input wire logic [31:0] cfg_data
);
	localparam int LW = rzc_pkg::LW;
	localparam int FW = rzc_pkg::FW;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_LRD = 4'd1;   // issue live read
	localparam logic [3:0] S_LCMP = 4'd2;  // compare live entry
	localparam logic [3:0] S_FRD = 4'd3;
	localparam logic [3:0] S_FCMP = 4'd4;
	localparam logic [3:0] S_LSH = 4'd5;   // shift live table down
	localparam logic [3:0] S_LSHW = 4'd6;
	localparam logic [3:0] S_FSH = 4'd7;   // shift freed table down
	localparam logic [3:0] S_FSHW = 4'd8;
	localparam logic [3:0] S_APP = 4'd9;   // append to freed table
	localparam logic [3:0] S_ARD = 4'd10;  // aging scan read
	localparam logic [3:0] S_ACMP = 4'd11;
	localparam logic [3:0] S_CHK = 4'd12;  // bounds check
	localparam logic [3:0] S_OUT = 4'd13;

	localparam int LIVE_ENTRIES_M1 = rzc_pkg::LIVE_ENTRIES - 1;

	logic [3:0] state_q;
	logic [2:0] cmd_q;
	logic [31:0] addr_q, len_q, key_q;
	logic [12:0] rz_q;
	logic [31:0] age_q, tick_q;
	logic [LW:0] ln_q;
	logic [FW:0] fn_q;
	logic [LW-1:0] li_q;
	logic [FW-1:0] fi_q;
	logic [LW:0] lp_q;
	logic [FW:0] fp_q;
	logic [LIVE_ENTRIES_M1:0] lwr_q;
	logic [3:0] st_q;
	logic un_q;
	logic aging_q;
	logic [31:0] hb_q, hs_q;
	logic [LW-1:0] hit_q;

	// live and freed RAM port signals
	logic l_we;
	logic [LW-1:0] l_wa, l_ra;
	logic [63:0] l_wd, l_rd;
	logic f_we;
	logic [FW-1:0] f_wa, f_ra;
	logic [95:0] f_wd, f_rd;

	rzc_ram #(.WIDTH(64), .DEPTH(rzc_pkg::LIVE_ENTRIES)) u_live (
		.clk(clk), .we(l_we), .waddr(l_wa), .wdata(l_wd), .raddr(l_ra), .rdata(l_rd)
	);
	rzc_ram #(.WIDTH(96), .DEPTH(rzc_pkg::FREED_ENTRIES)) u_freed (
		.clk(clk), .we(f_we), .waddr(f_wa), .wdata(f_wd), .raddr(f_ra), .rdata(f_rd)
	);

	logic [31:0] rb, rs;
	logic [32:0] rend, lo, hi, aend;
	logic rin;
	logic [31:0] fb, ft;

	assign rb = (state_q == S_LCMP) ? l_rd[63:32] : f_rd[95:64];
	assign rs = (state_q == S_LCMP) ? l_rd[31:0] : f_rd[63:32];
	assign fb = f_rd[95:64];
	assign ft = f_rd[31:0];
	assign rend = {1'b0, rb} + {1'b0, rs};
	assign rin = (rb <= addr_q) && ({1'b0, addr_q} <= rend);
	assign lo = {1'b0, hb_q} + {20'd0, rz_q};
	assign hi = {1'b0, hb_q} + {1'b0, hs_q} - {20'd0, rz_q};
	assign aend = {1'b0, addr_q} + {1'b0, len_q};

	assign in_ready = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = (state_q == S_OUT);
	assign status = st_q;
	assign uninit_read = un_q;

	always_comb begin
		l_we = 1'b0;
		l_wa = li_q;
		l_wd = l_rd;
		l_ra = li_q;
		f_we = 1'b0;
		f_wa = fi_q;
		f_wd = f_rd;
		f_ra = fi_q;
		case (state_q)
			S_IDLE: begin
				l_we = in_valid && (command == rzc_pkg::CMD_ALLOC) && !ln_q[LW];
				l_wa = ln_q[LW-1:0];
				l_wd = {address, length};
				l_ra = '0;
				f_ra = '0;
			end
			S_LSH: l_ra = li_q + LW'(1);
			S_LSHW: begin
				l_we = 1'b1;
				l_wa = li_q;
			end
			S_FSH: f_ra = fi_q + FW'(1);
			S_FSHW: begin
				f_we = 1'b1;
				f_wa = fi_q;
			end
			S_APP: begin
				f_we = 1'b1;
				f_wa = fn_q[FW-1:0];
				f_wd = {hb_q, hs_q, tick_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rz_q <= 13'd4;
			age_q <= 32'd60;
			tick_q <= '0;
			ln_q <= '0;
			fn_q <= '0;
			lwr_q <= '0;
			li_q <= '0;
			fi_q <= '0;
			lp_q <= '0;
			fp_q <= '0;
			st_q <= rzc_pkg::ST_OK;
			un_q <= 1'b0;
			aging_q <= 1'b0;
			cmd_q <= '0;
			hit_q <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					rzc_pkg::CFG_RZ: rz_q <= cfg_data[12:0];
					default: age_q <= cfg_data;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd_q <= command;
						addr_q <= address;
						len_q <= length;
						key_q <= address - {19'd0, rz_q};
						un_q <= 1'b0;
						li_q <= '0;
						fi_q <= '0;
						lp_q <= '0;
						fp_q <= '0;
						aging_q <= 1'b0;
						case (command)
							rzc_pkg::CMD_ALLOC: begin
								state_q <= S_OUT;
								if (ln_q[LW]) begin
									st_q <= rzc_pkg::ST_FULL;
								end else begin
									st_q <= rzc_pkg::ST_OK;
									lwr_q[ln_q[LW-1:0]] <= 1'b0;
									ln_q <= ln_q + 1'b1;
								end
							end
							rzc_pkg::CMD_TICK: begin
								st_q <= rzc_pkg::ST_OK;
								state_q <= S_OUT;
								tick_q <= tick_q + 32'd1;
							end
							rzc_pkg::CMD_FREE: begin
								st_q <= rzc_pkg::ST_OK;
								state_q <= S_LRD;
							end
							rzc_pkg::CMD_READ, rzc_pkg::CMD_WRITE: begin
								if (address == 32'd0) begin
									st_q <= rzc_pkg::ST_NULL;
									state_q <= S_OUT;
								end else begin
									st_q <= rzc_pkg::ST_OK;
									state_q <= S_LRD;
								end
							end
							default: begin
								st_q <= rzc_pkg::ST_OK;
								state_q <= S_OUT;
							end
						endcase
					end
				end
				S_LRD: begin
					if (lp_q == ln_q) begin
						state_q <= S_FRD;
					end else begin
						state_q <= S_LCMP;
					end
				end
				S_LCMP: begin
					if ((cmd_q == rzc_pkg::CMD_FREE) ? (l_rd[63:32] == key_q) : rin) begin
						hb_q <= l_rd[63:32];
						hs_q <= l_rd[31:0];
						hit_q <= li_q;
						if (cmd_q == rzc_pkg::CMD_FREE) begin
							state_q <= S_LSH;
						end else begin
							state_q <= S_CHK;
						end
					end else begin
						li_q <= li_q + LW'(1);
						lp_q <= lp_q + 1'b1;
						state_q <= S_LRD;
					end
				end
				S_FRD: begin
					if (fp_q == fn_q) begin
						st_q <= (cmd_q == rzc_pkg::CMD_FREE) ? rzc_pkg::ST_BADFREE
							: rzc_pkg::ST_OK;
						state_q <= S_OUT;
					end else begin
						state_q <= S_FCMP;
					end
				end
				S_FCMP: begin
					if ((cmd_q == rzc_pkg::CMD_FREE) ? (fb == key_q) : rin) begin
						st_q <= (cmd_q == rzc_pkg::CMD_FREE) ? rzc_pkg::ST_REFREE
							: (cmd_q == rzc_pkg::CMD_WRITE) ? rzc_pkg::ST_WFREED
							: rzc_pkg::ST_RFREED;
						state_q <= S_OUT;
					end else begin
						fi_q <= fi_q + FW'(1);
						fp_q <= fp_q + 1'b1;
						state_q <= S_FRD;
					end
				end
				S_LSH: begin
					if ({1'b0, li_q} + 1'b1 >= ln_q) begin
						ln_q <= ln_q - 1'b1;
						fi_q <= '0;
						if (fn_q[FW]) begin
							aging_q <= 1'b0;
							state_q <= S_FSH;
						end else begin
							state_q <= S_APP;
						end
					end else begin
						lwr_q[li_q] <= lwr_q[li_q + LW'(1)];
						state_q <= S_LSHW;
					end
				end
				S_LSHW: begin
					li_q <= li_q + LW'(1);
					state_q <= S_LSH;
				end
				S_FSH: begin
					if ({1'b0, fi_q} + 1'b1 >= fn_q) begin
						fn_q <= fn_q - 1'b1;
						// resume the aging scan at the removed slot
						fi_q <= fp_q[FW-1:0];
						if (aging_q) begin
							state_q <= S_ARD;
						end else begin
							state_q <= S_APP;
						end
					end else begin
						state_q <= S_FSHW;
					end
				end
				S_FSHW: begin
					fi_q <= fi_q + FW'(1);
					state_q <= S_FSH;
				end
				S_APP: begin
					fn_q <= fn_q + 1'b1;
					fi_q <= '0;
					fp_q <= '0;
					aging_q <= 1'b1;
					state_q <= S_ARD;
				end
				S_ARD: begin
					if ({1'b0, fi_q} >= fn_q || fn_q == '0) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_ACMP;
					end
				end
				S_ACMP: begin
					if ((tick_q - ft) > age_q) begin
						fp_q <= {1'b0, fi_q};
						state_q <= S_FSH;
					end else if ({1'b0, fi_q} + 1'b1 >= fn_q) begin
						state_q <= S_OUT;
					end else begin
						fi_q <= fi_q + FW'(1);
						state_q <= S_ARD;
					end
				end
				S_CHK: begin
					if (cmd_q == rzc_pkg::CMD_WRITE) begin
						lwr_q[hit_q] <= 1'b1;
					end else begin
						un_q <= !lwr_q[hit_q];
					end
					if ({1'b0, addr_q} < lo) begin
						st_q <= (cmd_q == rzc_pkg::CMD_WRITE) ? rzc_pkg::ST_UNDERW
							: rzc_pkg::ST_UNDERR;
					end else if ({1'b0, addr_q} >= hi || aend > hi
						|| hi[32] && !(hb_q[31] || hs_q[31])) begin
						st_q <= (cmd_q == rzc_pkg::CMD_WRITE) ? rzc_pkg::ST_OVERW
							: rzc_pkg::ST_OVERR;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) ln_q <= (LW+1)'(rzc_pkg::LIVE_ENTRIES))
		else $error("live count overflow");
	assert property (@(posedge clk) disable iff (!arst_n) fn_q <= (FW+1)'(rzc_pkg::FREED_ENTRIES))
		else $error("freed count overflow");
	assert property (@(posedge clk) disable iff (!arst_n) out_valid |-> !in_ready)
		else $error("busy while result pending");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status))
		else $error("result changed under stall");
endmodule
`default_nettype wire

/* sim/redzone_access_checker_tb.sv */
// Testbench for redzone_access_checker: drives alloc, free, access and tick requests with
// random idling and compares each result against a local model of the region tables.
// Depends on rzc_pkg and the checker RTL.
`default_nettype none
module redzone_access_checker_tb;
	typedef struct packed {
		logic [2:0] cmd;
		logic [31:0] addr;
		logic [31:0] len;
	} req_t;
	typedef struct packed {
		logic [3:0] st;
		logic uninit;
	} rsp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [2:0] command = '0;
	logic [31:0] address = '0;
	logic [31:0] length = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [3:0] status;
	logic uninit_read;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [0:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	always #2 clk = ~clk;

	redzone_access_checker i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .address(address), .length(length),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .uninit_read(uninit_read),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// model state: tables kept as ordered queues
	logic [31:0] live_b[$], live_s[$];
	logic live_w[$];
	logic [31:0] frd_b[$], frd_s[$], frd_t[$];
	logic [31:0] ticks = '0;
	logic [31:0] rz_m = 32'd4;
	logic [31:0] age_m = 32'd60;

	req_t pending[$];
	rsp_t expected[$];
	int errors = 0;
	int cycles = 0;
	bit stim_done = 0;
	bit hold_long = 0;
	bit hold_go = 0;
	int hold_cnt = 0;
	int send_gap = 0, recv_gap = 0;

	function automatic bit covers(logic [31:0] b, logic [31:0] s, logic [31:0] a);
		return b <= a && {32'd0, a} <= {32'd0, b} + {32'd0, s};
	endfunction

	function automatic rsp_t apply_request(req_t r);
		rsp_t o;
		logic [31:0] p, b, s;
		longint lo, hi;
		int i, hit;
		o = '{st: rzc_pkg::ST_OK, uninit: 1'b0};
		case (r.cmd)
			rzc_pkg::CMD_ALLOC: begin
				if (live_b.size() >= rzc_pkg::LIVE_ENTRIES) o.st = rzc_pkg::ST_FULL;
				else begin
					live_b.push_back(r.addr);
					live_s.push_back(r.len);
					live_w.push_back(1'b0);
				end
			end
			rzc_pkg::CMD_FREE: begin
				p = r.addr - rz_m;
				hit = -1;
				foreach (live_b[k]) if (hit < 0 && live_b[k] == p) hit = k;
				if (hit < 0) begin
					o.st = rzc_pkg::ST_BADFREE;
					foreach (frd_b[k]) if (frd_b[k] == p) o.st = rzc_pkg::ST_REFREE;
				end else begin
					b = live_b[hit];
					s = live_s[hit];
					live_b.delete(hit);
					live_s.delete(hit);
					live_w.delete(hit);
					if (frd_b.size() >= rzc_pkg::FREED_ENTRIES) begin
						frd_b.delete(0);
						frd_s.delete(0);
						frd_t.delete(0);
					end
					frd_b.push_back(b);
					frd_s.push_back(s);
					frd_t.push_back(ticks);
					i = 0;
					while (i < frd_b.size()) begin
						if (ticks - frd_t[i] > age_m) begin
							frd_b.delete(i);
							frd_s.delete(i);
							frd_t.delete(i);
						end else i++;
					end
				end
			end
			rzc_pkg::CMD_READ, rzc_pkg::CMD_WRITE: begin
				if (r.addr == 0) o.st = rzc_pkg::ST_NULL;
				else begin
					hit = -1;
					foreach (live_b[k])
						if (hit < 0 && covers(live_b[k], live_s[k], r.addr)) hit = k;
					if (hit < 0) begin
						foreach (frd_b[k])
							if (hit < 0 && covers(frd_b[k], frd_s[k], r.addr)) hit = k;
						if (hit >= 0) o.st = (r.cmd == rzc_pkg::CMD_WRITE) ? rzc_pkg::ST_WFREED
							: rzc_pkg::ST_RFREED;
					end else begin
						if (r.cmd == rzc_pkg::CMD_WRITE) live_w[hit] = 1'b1;
						else if (!live_w[hit]) o.uninit = 1'b1;
						lo = longint'(live_b[hit]) + longint'(rz_m);
						hi = longint'(live_b[hit]) + longint'(live_s[hit]) - longint'(rz_m);
						if (longint'(r.addr) < lo)
							o.st = (r.cmd == rzc_pkg::CMD_WRITE) ? rzc_pkg::ST_UNDERW
								: rzc_pkg::ST_UNDERR;
						else if (longint'(r.addr) >= hi ||
								longint'(r.addr) + longint'(r.len) > hi)
							o.st = (r.cmd == rzc_pkg::CMD_WRITE) ? rzc_pkg::ST_OVERW
								: rzc_pkg::ST_OVERR;
					end
				end
			end
			rzc_pkg::CMD_TICK: ticks = ticks + 1;
			default: ;
		endcase
		return o;
	endfunction

	function automatic int pick_gap();
		if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
		if ($urandom_range(0, 2) == 0) return 0;
		return $urandom_range(0, 3);
	endfunction

	// driver
	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			expected.push_back(apply_request('{cmd: command, addr: address, len: length}));
			in_valid <= 1'b0;
			send_gap <= pick_gap();
		end else if (!in_valid) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
			end else if (pending.size() > 0) begin
				req_t r;
				r = pending.pop_front();
				in_valid <= 1'b1;
				command <= r.cmd;
				address <= r.addr;
				length <= r.len;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (out_valid && out_ready) begin
			if (expected.size() == 0) begin
				$error("unexpected result status=%0d", status);
				errors++;
			end else begin
				rsp_t e;
				e = expected.pop_front();
				if (status !== e.st) begin
					$error("status expected %0d actual %0d", e.st, status);
					errors++;
				end
				if (uninit_read !== e.uninit) begin
					$error("uninit_read expected %0d actual %0d", e.uninit, uninit_read);
					errors++;
				end
			end
		end
		if (hold_long) out_ready <= 1'b0;
		else if (recv_gap > 0) begin
			out_ready <= 1'b0;
			recv_gap <= recv_gap - 1;
		end else if (out_valid && out_ready) begin
			recv_gap <= pick_gap();
			out_ready <= 1'b0;
		end else out_ready <= 1'b1;
	end

	// long receiver hold-off, counted here once started
	always @(posedge clk) begin
		if (hold_long) begin
			if (hold_cnt == 299) hold_long <= 1'b0;
			hold_cnt <= hold_cnt + 1;
		end else if (hold_go && hold_cnt == 0) begin
			hold_long <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (cycles > 10000000) begin
			$display("redzone_access_checker: mismatch");
			$finish;
		end
	end

	// region helpers for stimulus
	logic [31:0] bases[$];
	logic [31:0] sizes[$];

	task automatic add(logic [2:0] c, logic [31:0] a, logic [31:0] l);
		pending.push_back('{cmd: c, addr: a, len: l});
	endtask

	task automatic drain();
		wait (pending.size() == 0 && !in_valid && expected.size() == 0);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_cfg(logic [0:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == rzc_pkg::CFG_RZ) rz_m = {19'd0, val[12:0]};
		else age_m = val;
	endtask

	task automatic random_phase(int count);
		int k, sel, j;
		logic [31:0] a, b, s;
		for (k = 0; k < count; k++) begin
			sel = $urandom_range(0, 99);
			j = bases.size() > 0 ? $urandom_range(0, bases.size() - 1) : 0;
			if (sel < 18 || bases.size() == 0) begin
				b = ($urandom_range(0, 3) == 0) ? $urandom : $urandom & 32'h000f_fff0;
				s = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 300);
				bases.push_back(b);
				sizes.push_back(s);
				add(rzc_pkg::CMD_ALLOC, b, s);
			end else if (sel < 30) begin
				a = ($urandom_range(0, 5) == 0) ? $urandom : bases[j] + rz_m;
				add(rzc_pkg::CMD_FREE, a, $urandom);
				if ($urandom_range(0, 2) != 0) begin
					bases.delete(j);
					sizes.delete(j);
				end
			end else if (sel < 85) begin
				case ($urandom_range(0, 4))
					0: a = bases[j] + $urandom_range(0, 8);
					1: a = bases[j] + sizes[j] - $urandom_range(0, 8);
					2: a = $urandom;
					3: a = 32'd0;
					default: a = bases[j] + (sizes[j] == 0 ? 0 : $urandom_range(0, sizes[j]));
				endcase
				add($urandom_range(0, 1) ? rzc_pkg::CMD_WRITE : rzc_pkg::CMD_READ, a,
					$urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 16));
			end else if (sel < 97) add(rzc_pkg::CMD_TICK, $urandom, $urandom);
			else add(3'($urandom_range(5, 7)), $urandom, $urandom);
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		// directed
		add(rzc_pkg::CMD_READ, 32'd0, 32'd4);
		add(rzc_pkg::CMD_WRITE, 32'd0, 32'hffff_ffff);
		add(rzc_pkg::CMD_ALLOC, 32'h100, 32'd32);
		add(rzc_pkg::CMD_READ, 32'h108, 32'd4);
		add(rzc_pkg::CMD_WRITE, 32'h100, 32'd1);
		add(rzc_pkg::CMD_WRITE, 32'h11c, 32'd1);
		add(rzc_pkg::CMD_WRITE, 32'h118, 32'd8);
		add(rzc_pkg::CMD_READ, 32'h108, 32'd4);
		add(rzc_pkg::CMD_READ, 32'h120, 32'd0);
		add(rzc_pkg::CMD_ALLOC, 32'hffff_fff0, 32'hffff_ffff);
		add(rzc_pkg::CMD_READ, 32'hffff_ffff, 32'hffff_ffff);
		add(rzc_pkg::CMD_FREE, 32'h104, 32'd0);
		add(rzc_pkg::CMD_READ, 32'h110, 32'd1);
		add(rzc_pkg::CMD_WRITE, 32'h110, 32'd1);
		add(rzc_pkg::CMD_FREE, 32'h104, 32'd0);
		add(rzc_pkg::CMD_FREE, 32'h5555, 32'd0);
		add(rzc_pkg::CMD_FREE, 32'd0, 32'd0);
		add(rzc_pkg::CMD_READ, 32'h7000_0000, 32'd1);
		add(rzc_pkg::CMD_TICK, 32'hffff_ffff, 32'hffff_ffff);
		add(3'd7, 32'hffff_ffff, 32'hffff_ffff);
		for (int k = 0; k < 65; k++) add(rzc_pkg::CMD_ALLOC, 32'h1_0000 + k * 64, 32'd40);
		drain();
		// fill the block while the receiver holds off
		hold_go = 1;
		random_phase(20);
		wait (hold_cnt >= 300);
		drain();
		write_cfg(rzc_pkg::CFG_RZ, 32'd0);
		write_cfg(rzc_pkg::CFG_AGE, 32'd0);
		random_phase(200);
		drain();
		write_cfg(rzc_pkg::CFG_RZ, 32'hffff_f000);
		write_cfg(rzc_pkg::CFG_AGE, 32'hffff_ffff);
		random_phase(150);
		drain();
		write_cfg(rzc_pkg::CFG_RZ, 32'd16);
		write_cfg(rzc_pkg::CFG_AGE, 32'd3);
		random_phase(200);
		drain();
		if (errors == 0) $display("redzone_access_checker: match");
		else $display("redzone_access_checker: mismatch");
		$finish;
	end
endmodule
`default_nettype wire

/* filelist.f */
hw/rtl/rzc_pkg.sv
hw/rtl/rzc_ram.sv
hw/rtl/redzone_access_checker.sv
sim/redzone_access_checker_tb.sv
